// ===== rtl/sri_pkg.sv =====
package sri_pkg;

    localparam int CoordWidth = 32;
    localparam int DiffWidth = CoordWidth + 1;
    localparam int ProdWidth = 2 * DiffWidth;
    localparam int DetWidth = ProdWidth + 1;
    localparam int ParamFracBits = 24;
    localparam int NumEdges = 4;
    localparam int EdgeIdxWidth = 2;
    localparam int InDataWidth = 8 * CoordWidth;
    localparam int OutDataWidth = 32;

    typedef logic signed [CoordWidth-1:0] coord_t;
    typedef logic signed [DiffWidth-1:0] diff_t;
    typedef logic signed [ProdWidth-1:0] prod_t;
    typedef logic signed [DetWidth-1:0] det_t;
    typedef logic [ParamFracBits-1:0] param_t;
    typedef logic [EdgeIdxWidth-1:0] edge_idx_t;

    typedef enum logic [EdgeIdxWidth-1:0] {
        EDGE_LEFT   = 2'd0,
        EDGE_BOTTOM = 2'd1,
        EDGE_RIGHT  = 2'd2,
        EDGE_TOP    = 2'd3
    } edge_t;

    // Control that travels beside one edge's divider.
    typedef struct packed {
        logic   cand;
    } edge_ctl_t;

endpackage

// ===== rtl/segment_rectangle_intersection.sv =====
// Segment versus axis-aligned rectangle test, fully pipelined. One request is
// accepted every cycle while m_tready allows; each result reaches m_tdata
// through two stages of exact products and sums, 24 one-bit stages of
// restoring division, then the nearest-edge selection feeding the output
// register. The whole pipeline advances together only when the output
// register is empty or being taken, so a stall holds every stage and nothing
// is lost or repeated.
// s_tdata carries, from bit 0 upward, start_x, start_y, end_x, end_y,
// rect_left, rect_top, rect_right, rect_bottom, each 32-bit signed Q16.16.
// m_tdata carries hit in bit 0, edge_index in bits 2:1 and hit_param, an
// unsigned Q0.24 parameter, in bits 26:3; no hit reports all zeros.
module segment_rectangle_intersection (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // start_x, start_y, end_x, end_y, rect_left, rect_top, rect_right, rect_bottom
    input  logic [sri_pkg::InDataWidth-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // hit, edge_index, hit_param, zero fill
    output logic [sri_pkg::OutDataWidth-1:0] m_tdata
);
    import sri_pkg::*;

    localparam int Depth = ParamFracBits + 2;

    coord_t sx, sy, ex, ey, l, tp, rt, bt;
    logic   en;
    logic   vld_reg [Depth];
    logic   vld_next;

    assign sx = s_tdata[0*CoordWidth +: CoordWidth];
    assign sy = s_tdata[1*CoordWidth +: CoordWidth];
    assign ex = s_tdata[2*CoordWidth +: CoordWidth];
    assign ey = s_tdata[3*CoordWidth +: CoordWidth];
    assign l  = s_tdata[4*CoordWidth +: CoordWidth];
    assign tp = s_tdata[5*CoordWidth +: CoordWidth];
    assign rt = s_tdata[6*CoordWidth +: CoordWidth];
    assign bt = s_tdata[7*CoordWidth +: CoordWidth];

    // The pipeline moves whenever the output register can take a new value.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic      faces [NumEdges];
    coord_t    ecx [NumEdges], ecy [NumEdges], edx [NumEdges], edy [NumEdges];
    logic      cand [NumEdges];
    det_t      den [NumEdges], num [NumEdges];
    edge_ctl_t ctl_o [NumEdges];
    param_t    quo [NumEdges];

    always_comb begin
        faces[EDGE_LEFT]   = sx < ex;
        faces[EDGE_BOTTOM] = ey < sy;
        faces[EDGE_RIGHT]  = ex < sx;
        faces[EDGE_TOP]    = sy < ey;
        ecx[EDGE_LEFT] = l;  ecy[EDGE_LEFT] = tp;  edx[EDGE_LEFT] = l;  edy[EDGE_LEFT] = bt;
        ecx[EDGE_BOTTOM] = l; ecy[EDGE_BOTTOM] = bt;
        edx[EDGE_BOTTOM] = rt; edy[EDGE_BOTTOM] = bt;
        ecx[EDGE_RIGHT] = rt; ecy[EDGE_RIGHT] = bt;
        edx[EDGE_RIGHT] = rt; edy[EDGE_RIGHT] = tp;
        ecx[EDGE_TOP] = rt; ecy[EDGE_TOP] = tp; edx[EDGE_TOP] = l; edy[EDGE_TOP] = tp;
    end

    for (genvar e = 0; e < NumEdges; e++) begin : g_edge
        edge_ctl_t ci;
        assign ci.cand = cand[e];
        sri_edge_det u_det (
            .aclk(aclk), .en(en), .faces(faces[e]),
            .ax(sx), .ay(sy), .bx(ex), .by(ey),
            .cx(ecx[e]), .cy(ecy[e]), .dx(edx[e]), .dy(edy[e]),
            .cand(cand[e]), .den(den[e]), .num(num[e])
        );
        sri_div u_div (
            .aclk(aclk), .en(en), .ctl_in(ci), .den(den[e]), .num(num[e]),
            .ctl_out(ctl_o[e]), .quo(quo[e])
        );
    end

    // Valid bits ride alongside the data through the determinant and divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Depth; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < Depth; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Nearest hit; a strictly smaller parameter is needed to displace a lower edge.
    logic      found;
    param_t    best;
    edge_idx_t best_e;
    always_comb begin
        found  = 1'b0;
        best   = '0;
        best_e = '0;
        for (int e = 0; e < NumEdges; e++) begin
            if (ctl_o[e].cand && (!found || quo[e] < best)) begin
                found  = 1'b1;
                best   = quo[e];
                best_e = EdgeIdxWidth'(e);
            end
        end
    end

    logic      m_tvalid_reg;
    logic [OutDataWidth-1:0] m_tdata_reg;
    assign vld_next = vld_reg[Depth-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= OutDataWidth'({best, best_e, found});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef NO_ASSERTIONS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[OutDataWidth-1:1] == '0)
        else $error("miss with nonzero fields");
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready out of step with output");
`endif
endmodule

// ===== rtl/sri_edge_det.sv =====
// Forms the determinant and both numerators of one segment/edge pair over
// two register stages (differences and products, then sums with sign fix).
module sri_edge_det (
    input  logic                 aclk,
    input  logic                 en,
    input  logic                 faces,
    input  sri_pkg::coord_t      ax,
    input  sri_pkg::coord_t      ay,
    input  sri_pkg::coord_t      bx,
    input  sri_pkg::coord_t      by,
    input  sri_pkg::coord_t      cx,
    input  sri_pkg::coord_t      cy,
    input  sri_pkg::coord_t      dx,
    input  sri_pkg::coord_t      dy,
    output logic                 cand,
    output sri_pkg::det_t        den,
    output sri_pkg::det_t        num
);
    import sri_pkg::*;

    diff_t t1, t2, t3, t4, t5, t6;
    prod_t p12_reg, p34_reg, p54_reg, p62_reg, p51_reg, p63_reg;
    logic  faces_reg;
    det_t  den_s, n1_s, n2_s, den_a, n1_a, n2_a;
    logic  ok;

    assign t1 = DiffWidth'(bx) - DiffWidth'(ax);
    assign t2 = DiffWidth'(dy) - DiffWidth'(cy);
    assign t3 = DiffWidth'(by) - DiffWidth'(ay);
    assign t4 = DiffWidth'(dx) - DiffWidth'(cx);
    assign t5 = DiffWidth'(ay) - DiffWidth'(cy);
    assign t6 = DiffWidth'(ax) - DiffWidth'(cx);

    always_ff @(posedge aclk) begin
        if (en) begin
            p12_reg   <= t1 * t2;
            p34_reg   <= t3 * t4;
            p54_reg   <= t5 * t4;
            p62_reg   <= t6 * t2;
            p51_reg   <= t5 * t1;
            p63_reg   <= t6 * t3;
            faces_reg <= faces;
        end
    end

    always_comb begin
        den_s = DetWidth'(p12_reg) - DetWidth'(p34_reg);
        n1_s  = DetWidth'(p54_reg) - DetWidth'(p62_reg);
        n2_s  = DetWidth'(p51_reg) - DetWidth'(p63_reg);
        den_a = den_s[DetWidth-1] ? -den_s : den_s;
        n1_a  = den_s[DetWidth-1] ? -n1_s : n1_s;
        n2_a  = den_s[DetWidth-1] ? -n2_s : n2_s;
        ok = faces_reg && (den_s != '0)
             && (n1_a > 0) && (n1_a < den_a) && (n2_a > 0) && (n2_a < den_a);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cand <= ok;
            den  <= den_a;
            num  <= n1_a;
        end
    end
endmodule

// ===== rtl/sri_div.sv =====
// Pipelined restoring division: one quotient bit per stage, floor(num*2^F/den).
module sri_div (
    input  logic                 aclk,
    input  logic                 en,
    input  sri_pkg::edge_ctl_t   ctl_in,
    input  sri_pkg::det_t        den,
    input  sri_pkg::det_t        num,
    output sri_pkg::edge_ctl_t   ctl_out,
    output sri_pkg::param_t      quo
);
    import sri_pkg::*;

    localparam int RemWidth = DetWidth + 1;

    logic [RemWidth-1:0] rem_reg [1:ParamFracBits];
    logic [RemWidth-1:0] den_reg [1:ParamFracBits];
    param_t              q_reg   [1:ParamFracBits];
    edge_ctl_t           ctl_reg [1:ParamFracBits];

    for (genvar i = 0; i < ParamFracBits; i++) begin : g_stage
        logic [RemWidth-1:0] rem_in;
        logic [RemWidth-1:0] den_in;
        param_t              q_in;
        edge_ctl_t           ctl_s;
        logic [RemWidth-1:0] sh;
        logic                ge;
        if (i == 0) begin : g_first
            assign rem_in = RemWidth'(unsigned'(num));
            assign den_in = RemWidth'(unsigned'(den));
            assign q_in   = '0;
            assign ctl_s  = ctl_in;
        end else begin : g_next
            assign rem_in = rem_reg[i];
            assign den_in = den_reg[i];
            assign q_in   = q_reg[i];
            assign ctl_s  = ctl_reg[i];
        end
        assign sh = rem_in << 1;
        assign ge = sh >= den_in;
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= ge ? sh - den_in : sh;
                den_reg[i+1] <= den_in;
                q_reg[i+1]   <= {q_in[ParamFracBits-2:0], ge};
                ctl_reg[i+1] <= ctl_s;
            end
        end
    end

    assign quo     = q_reg[ParamFracBits];
    assign ctl_out = ctl_reg[ParamFracBits];
endmodule
